[sv/dfe_pkg.sv]
// dfe_pkg: shared types, constants and the frame checksum function for the
// four-motor DShot frame encoder. No dependencies.
package dfe_pkg;

	localparam int MOTOR_COUNT   = 4;
	localparam int MOTOR_W       = 2;
	localparam int FRAME_BITS    = 16;
	localparam int SLOTS_PER_BIT = 4;
	localparam int BURST_SLOTS   = FRAME_BITS * SLOTS_PER_BIT;
	localparam int SLOT_CNT_W    = $clog2(BURST_SLOTS);
	localparam int PHASE_W       = $clog2(SLOTS_PER_BIT);
	localparam int BIT_IDX_W     = $clog2(FRAME_BITS);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MIN_SPIN        = 2'd0;
	localparam cfg_idx_t CFG_BIDIRECTIONAL   = 2'd1;
	localparam cfg_idx_t CFG_REVERSE_DIR     = 2'd2;
	localparam cfg_idx_t CFG_FAILSAFE_TIMEOUT = 2'd3;

	localparam logic [8:0]  RST_MIN_SPIN         = 9'd40;
	localparam logic        RST_BIDIRECTIONAL    = 1'b1;
	localparam logic        RST_REVERSE_DIR      = 1'b0;
	localparam logic [23:0] RST_FAILSAFE_TIMEOUT = 24'd100000;

	localparam logic MODE_THROTTLE = 1'b0;
	localparam logic MODE_COMMAND  = 1'b1;

	localparam logic [10:0] THR_MAX  = 11'd1022;
	localparam logic [11:0] FWD_BASE = 12'd48;
	localparam logic [11:0] REV_BASE = 12'd1048;
	localparam logic [11:0] SPAN_3D  = 12'd1000;
	localparam logic [11:0] SPAN_UNI = 12'd2001;

	typedef logic [FRAME_BITS-1:0] frame_t;

	typedef struct packed {
		logic [8:0]  min_spin;
		logic        bidirectional;
		logic        reverse_direction;
		logic [23:0] failsafe_timeout_us;
	} cfg_t;

	typedef struct packed {
		logic               mode;
		logic [MOTOR_W-1:0] motor;
		logic signed [11:0] throttle;
		logic [10:0]        command_value;
		logic [31:0]        now_us;
		logic               on_ground;
		logic               failsafe_active;
	} item_t;

	typedef struct packed {
		logic                   load;
		logic [MOTOR_COUNT-1:0] pending;
	} burst_req_t;

	// 12-bit payload value<<1|telemetry, then XOR of its three nibbles
	function automatic frame_t build_frame(input logic [10:0] value, input logic tel);
		logic [11:0] p;
		logic [3:0]  c;
		p = {value, tel};
		c = p[3:0] ^ p[7:4] ^ p[11:8];
		return {p, c};
	endfunction

endpackage

[sv/dfe_item_if.sv]
// dfe_item_if: input item channel, valid/ready plus the item fields.
// Depends on dfe_pkg.
interface dfe_item_if import dfe_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [MOTOR_W-1:0] motor;
	logic signed [11:0] throttle;
	logic [10:0]        command_value;
	logic [31:0]        now_us;
	logic               on_ground;
	logic               failsafe_active;

	modport source (output valid, mode, motor, throttle, command_value, now_us,
		on_ground, failsafe_active, input ready);
	modport sink (input valid, mode, motor, throttle, command_value, now_us,
		on_ground, failsafe_active, output ready);
endinterface

[sv/dfe_slot_if.sv]
// dfe_slot_if: result channel, one quarter-bit slot of line levels per item.
// Depends on dfe_pkg.
interface dfe_slot_if import dfe_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [MOTOR_COUNT-1:0] slot_bits;
	logic                   last_slot;

	modport source (output valid, slot_bits, last_slot, input ready);
	modport sink (input valid, slot_bits, last_slot, output ready);
endinterface

[sv/dfe_cfg_if.sv]
// dfe_cfg_if: configuration write channel, register index and write data.
// Depends on dfe_pkg.
interface dfe_cfg_if import dfe_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/dfe_frame_enc.sv]
// dfe_frame_enc: throttle mapping, failsafe tracking and frame build for one item.
// Holds the failsafe timer state. Depends on dfe_pkg.
module dfe_frame_enc import dfe_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   fire,
	input  item_t  item,
	input  cfg_t   cfg,
	output frame_t frame
);

	logic [31:0] fs_start_q;
	logic        fs_timing_q;
	logic        fs_off_rst_q;

	logic [9:0]  thr;
	logic [11:0] span;
	logic [11:0] base;
	logic [21:0] prod;
	logic [10:0] mapped;
	logic [31:0] elapsed;
	logic        expired;
	logic        force_zero;
	logic [10:0] value;

	always_comb begin
		if (item.throttle[11])
			thr = '0;
		else if (item.throttle[10:0] > THR_MAX)
			thr = THR_MAX[9:0];
		else
			thr = item.throttle[9:0];

		if (cfg.bidirectional) begin
			span = SPAN_3D - 12'(cfg.min_spin);
			base = (cfg.reverse_direction ? REV_BASE : FWD_BASE) + 12'(cfg.min_spin);
		end else begin
			span = SPAN_UNI - 12'({cfg.min_spin, 1'b0});
			base = FWD_BASE + 12'({cfg.min_spin, 1'b0});
		end
	end

	assign prod   = 22'(thr) * 22'(span);
	assign mapped = 11'(base + prod[21:10]);

	assign elapsed = item.now_us - fs_start_q;
	assign expired = elapsed > 32'(cfg.failsafe_timeout_us);

	// on the first failsafe item after a non-failsafe one the timer starts and the value passes
	assign force_zero = item.on_ground ||
		(item.failsafe_active && fs_timing_q && (fs_off_rst_q || expired));

	always_comb begin
		if (item.mode == MODE_COMMAND)
			value = item.command_value;
		else if (force_zero)
			value = '0;
		else
			value = mapped;
	end

	assign frame = build_frame(value, item.mode == MODE_COMMAND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_timing_q  <= 1'b1;
			fs_off_rst_q <= 1'b1;
		end else if (fire && item.mode == MODE_THROTTLE) begin
			if (item.failsafe_active) begin
				fs_timing_q <= 1'b1;
			end else begin
				fs_timing_q  <= 1'b0;
				fs_off_rst_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item.mode == MODE_THROTTLE && item.failsafe_active && !fs_timing_q)
			fs_start_q <= item.now_us;
	end

endmodule

[sv/dfe_burst.sv]
// dfe_burst: snapshot of the four frames and the 64-slot line-level sequencer
// with its output register. Depends on dfe_pkg and dfe_slot_if.
module dfe_burst import dfe_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  burst_req_t                    req,
	input  frame_t [MOTOR_COUNT-1:0]      frames,
	output logic                          load_ready,
	dfe_slot_if.source                    slots
);

	localparam logic [SLOT_CNT_W-1:0] CNT_LAST   = SLOT_CNT_W'(BURST_SLOTS - 1);
	localparam logic [PHASE_W-1:0]    PHASE_LAST = PHASE_W'(SLOTS_PER_BIT - 1);
	localparam logic [BIT_IDX_W-1:0]  BIT_TOP    = BIT_IDX_W'(FRAME_BITS - 1);

	logic                          busy_q;
	logic [SLOT_CNT_W-1:0]         cnt_q;
	logic [MOTOR_COUNT-1:0]        pend_q;
	frame_t [MOTOR_COUNT-1:0]      frames_q;
	logic                          out_valid_q;
	logic [MOTOR_COUNT-1:0]        slot_q;
	logic                          last_q;

	logic                          adv;
	logic [BIT_IDX_W-1:0]          bit_idx;
	logic [PHASE_W-1:0]            phase;
	logic [MOTOR_COUNT-1:0]        level;

	// a new burst may load on the edge that issues the final slot
	assign load_ready = !busy_q || (adv && cnt_q == CNT_LAST);
	assign adv        = busy_q && (!out_valid_q || slots.ready);

	assign bit_idx = BIT_TOP - cnt_q[SLOT_CNT_W-1:PHASE_W];
	assign phase   = cnt_q[PHASE_W-1:0];

	always_comb begin
		for (int k = 0; k < MOTOR_COUNT; k++) begin
			if (phase == '0)
				level[k] = pend_q[k];
			else if (phase == PHASE_LAST)
				level[k] = 1'b0;
			else
				level[k] = pend_q[k] & frames_q[k][bit_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.load && load_ready) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				pend_q <= req.pending;
			end else if (adv) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (adv)
				out_valid_q <= 1'b1;
			else if (slots.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.load && load_ready)
			frames_q <= frames;
		if (adv) begin
			slot_q <= level;
			last_q <= (cnt_q == CNT_LAST);
		end
	end

	assign slots.valid     = out_valid_q;
	assign slots.slot_bits = slot_q;
	assign slots.last_slot = last_q;

`ifndef SYNTHESIS
	a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == '0)
		else $error("slot counter not parked while idle");

	a_last_slot_ends: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cnt_q == CNT_LAST |=> slots.valid && slots.last_slot)
		else $error("burst did not end on its last slot");

	a_load_snapshot: assert property (@(posedge clk) disable iff (!arst_n)
		req.load && load_ready |=> busy_q && pend_q == $past(req.pending))
		else $error("burst load lost pending marks");
`endif

endmodule

[sv/dshot_four_motor_frame_encoder_top.sv]
// Four-motor DShot frame encoder top: input register, frame store and burst; uses dfe_pkg.
// Output: a last-motor item passes the input register and the burst load before its first
// slot is registered, then one slot per cycle for 64 slots while the output is taken.
// Throughput: one item per cycle; a last-motor item waits in the input register until the
// running burst issues its final slot, so sets of four items are taken at the pace of the bursts.
// Reset (arst_n, async active low): nothing pending, config at defaults, failsafe held off.
module dshot_four_motor_frame_encoder_top import dfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dfe_item_if.sink   cmd,
	dfe_cfg_if.sink    cfg,
	dfe_slot_if.source slots
);

	cfg_t                   cfg_q;
	logic                   valid_s1;
	item_t                  item_s1;
	frame_t [MOTOR_COUNT-1:0] store_q;
	logic [MOTOR_COUNT-1:0] pending_q;

	frame_t                 new_frame;
	logic                   in_range;
	logic                   is_trigger;
	logic                   burst_ready;
	logic                   consume;
	logic [MOTOR_COUNT-1:0] motor_hot;
	burst_req_t             req;
	frame_t [MOTOR_COUNT-1:0] burst_frames;

	// configuration port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_spin            <= RST_MIN_SPIN;
			cfg_q.bidirectional       <= RST_BIDIRECTIONAL;
			cfg_q.reverse_direction   <= RST_REVERSE_DIR;
			cfg_q.failsafe_timeout_us <= RST_FAILSAFE_TIMEOUT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MIN_SPIN:         cfg_q.min_spin            <= cfg.data[8:0];
				CFG_BIDIRECTIONAL:    cfg_q.bidirectional       <= cfg.data[0];
				CFG_REVERSE_DIR:      cfg_q.reverse_direction   <= cfg.data[0];
				CFG_FAILSAFE_TIMEOUT: cfg_q.failsafe_timeout_us <= cfg.data[23:0];
				default: ;
			endcase
		end
	end

	// input register
	assign in_range   = 32'(item_s1.motor) < 32'(MOTOR_COUNT);
	assign is_trigger = item_s1.motor == MOTOR_W'(MOTOR_COUNT - 1);
	assign consume    = valid_s1 && (!is_trigger || burst_ready);
	assign cmd.ready  = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cmd.ready)
			valid_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.mode            <= cmd.mode;
			item_s1.motor           <= cmd.motor;
			item_s1.throttle        <= cmd.throttle;
			item_s1.command_value   <= cmd.command_value;
			item_s1.now_us          <= cmd.now_us;
			item_s1.on_ground       <= cmd.on_ground;
			item_s1.failsafe_active <= cmd.failsafe_active;
		end
	end

	dfe_frame_enc u_enc (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (consume && in_range),
		.item   (item_s1),
		.cfg    (cfg_q),
		.frame  (new_frame)
	);

	// the trigger item's own frame goes straight into the burst snapshot
	always_comb begin
		for (int k = 0; k < MOTOR_COUNT; k++) begin
			motor_hot[k]    = in_range && (item_s1.motor == MOTOR_W'(k));
			burst_frames[k] = motor_hot[k] ? new_frame : store_q[k];
		end
		req.load    = consume && in_range && is_trigger;
		req.pending = pending_q | motor_hot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (consume && in_range)
			pending_q <= is_trigger ? '0 : (pending_q | motor_hot);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MOTOR_COUNT; k++) begin
			if (consume && motor_hot[k])
				store_q[k] <= new_frame;
		end
	end

	dfe_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.frames     (burst_frames),
		.load_ready (burst_ready),
		.slots      (slots)
	);

`ifndef SYNTHESIS
	a_trigger_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && is_trigger && !burst_ready |=> valid_s1 && is_trigger)
		else $error("stalled trigger item dropped");

	a_held_item_stable: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !consume |=> valid_s1 && $stable(item_s1))
		else $error("waiting item changed");

	a_pending_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		req.load |=> pending_q == '0)
		else $error("pending marks survive a burst");
`endif

endmodule
